// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the scaler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion on clk_i, off while rst_ni is low.
`define CCNS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be true.
`define CCNS_NEVER(lbl, cond, msg) \
  `CCNS_ASSERT(lbl, !(cond), msg)

`endif

// ===== hdl/ccns_pkg.sv =====
// Types, constants and helper functions of the cover-crop nearest scaler.
package ccns_pkg;

  localparam int MAX_DIM       = 4096;
  localparam int CFG_W         = 13;
  localparam int COORD_W       = 12;
  localparam int ADDR_W        = 24;
  localparam int STEP_FRAC     = 16;
  localparam int STEP_W        = CFG_W + STEP_FRAC;
  localparam int PROD_W        = 2 * CFG_W;
  localparam int APB_AW        = 4;
  localparam int APB_DW        = 32;
  localparam int DIV_PER_STAGE = 3;
  localparam int DIV_STAGES    = COORD_W / DIV_PER_STAGE;

  localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DST_WIDTH  = 2'd2;
  localparam logic [1:0] REG_DST_HEIGHT = 2'd3;

  // Geometry derived from the size registers, held while the block runs.
  typedef struct packed {
    logic               ok;
    logic [CFG_W-1:0]   sw;
    logic [CFG_W-1:0]   sh;
    logic [CFG_W-1:0]   dw;
    logic [CFG_W-1:0]   dh;
    logic [CFG_W-1:0]   crop_h;
    logic [COORD_W-1:0] off_x;
    logic [COORD_W-1:0] off_y;
    logic [STEP_W-1:0]  step;
  } ccns_geom_t;

  // Partial state of the row division: remainder, numerator bits left, quotient.
  typedef struct packed {
    logic [COORD_W-1:0] rem;
    logic [COORD_W-1:0] num;
    logic [COORD_W-1:0] quo;
  } ccns_div_t;

  function automatic logic size_ok(input logic [CFG_W-1:0] v);
    return (v != '0) && (v <= CFG_W'(MAX_DIM));
  endfunction

  // Three restoring division steps, one quotient bit each.
  function automatic ccns_div_t div_steps(input ccns_div_t s, input logic [CFG_W-1:0] d);
    ccns_div_t         r;
    logic [COORD_W:0]  part;
    r = s;
    for (int i = 0; i < DIV_PER_STAGE; i++) begin
      part  = {r.rem, r.num[COORD_W-1]};
      r.num = {r.num[COORD_W-2:0], 1'b0};
      if (part >= d) begin
        part  = part - d;
        r.quo = {r.quo[COORD_W-2:0], 1'b1};
      end else begin
        r.quo = {r.quo[COORD_W-2:0], 1'b0};
      end
      r.rem = part[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/ccns_setup.sv =====
// Size registers, APB access and serial derivation of crop, offsets and x step.
`include "assert_macros.svh"

module ccns_setup
  import ccns_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic              busy_o,
  output ccns_geom_t        geom_o
);

  localparam int CNT_W = $clog2(STEP_W);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_PROD     = 3'd1;
  localparam logic [2:0] ST_SEL      = 3'd2;
  localparam logic [2:0] ST_DIV_CROP = 3'd3;
  localparam logic [2:0] ST_DIV_STEP = 3'd4;
  localparam logic [2:0] ST_OFFS     = 3'd5;

  logic [CFG_W-1:0]   sw_q, sh_q, dw_q, dh_q;
  logic [CFG_W-1:0]   rdata;
  logic [1:0]         reg_idx;
  logic               wr;

  logic [2:0]         st_q, st_d;
  logic [PROD_W-1:0]  pa_q, pa_d, pb_q, pb_d;
  logic               wide_q, wide_d;
  logic [STEP_W-1:0]  div_n_q, div_n_d;
  logic [CFG_W-1:0]   div_r_q, div_r_d;
  logic [CFG_W-1:0]   div_d_q, div_d_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CFG_W-1:0]   crop_w_q, crop_w_d, crop_h_q, crop_h_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [COORD_W-1:0] off_x_q, off_x_d, off_y_q, off_y_d;

  logic [CFG_W:0]     part;
  logic               ge;
  logic [CFG_W-1:0]   rem_next;
  logic [STEP_W-1:0]  quo_next;
  logic [CFG_W-1:0]   crop_raw, crop_fix;
  logic               div_last;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign wr      = psel && penable && pwrite;

  always_comb begin
    unique case (reg_idx)
      REG_SRC_WIDTH:  rdata = sw_q;
      REG_SRC_HEIGHT: rdata = sh_q;
      REG_DST_WIDTH:  rdata = dw_q;
      REG_DST_HEIGHT: rdata = dh_q;
    endcase
  end
  assign prdata = APB_DW'(rdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= CFG_W'(1);
      sh_q <= CFG_W'(1);
      dw_q <= CFG_W'(1);
      dh_q <= CFG_W'(1);
    end else if (wr) begin
      unique case (reg_idx)
        REG_SRC_WIDTH:  sw_q <= pwdata[CFG_W-1:0];
        REG_SRC_HEIGHT: sh_q <= pwdata[CFG_W-1:0];
        REG_DST_WIDTH:  dw_q <= pwdata[CFG_W-1:0];
        REG_DST_HEIGHT: dh_q <= pwdata[CFG_W-1:0];
      endcase
    end
  end

  // one quotient bit per cycle
  assign part     = {div_r_q, div_n_q[STEP_W-1]};
  assign ge       = part >= {1'b0, div_d_q};
  assign rem_next = ge ? CFG_W'(part - {1'b0, div_d_q}) : part[CFG_W-1:0];
  assign quo_next = {div_n_q[STEP_W-2:0], ge};
  assign crop_raw = quo_next[CFG_W-1:0];
  assign crop_fix = (crop_raw == '0) ? CFG_W'(1) : crop_raw;
  assign div_last = cnt_q == CNT_W'(STEP_W - 1);

  always_comb begin
    st_d     = st_q;
    pa_d     = pa_q;
    pb_d     = pb_q;
    wide_d   = wide_q;
    div_n_d  = div_n_q;
    div_r_d  = div_r_q;
    div_d_d  = div_d_q;
    cnt_d    = cnt_q;
    crop_w_d = crop_w_q;
    crop_h_d = crop_h_q;
    step_d   = step_q;
    off_x_d  = off_x_q;
    off_y_d  = off_y_q;
    unique case (st_q)
      ST_IDLE: begin
      end
      ST_PROD: begin
        pa_d = PROD_W'(sw_q) * PROD_W'(dh_q);
        pb_d = PROD_W'(dw_q) * PROD_W'(sh_q);
        st_d = ST_SEL;
      end
      ST_SEL: begin
        // wider source: crop the width, else crop the height
        wide_d  = pa_q > pb_q;
        div_n_d = STEP_W'((pa_q > pb_q) ? pb_q : pa_q);
        div_d_d = (pa_q > pb_q) ? dh_q : dw_q;
        div_r_d = '0;
        cnt_d   = '0;
        st_d    = ST_DIV_CROP;
      end
      ST_DIV_CROP: begin
        div_n_d = quo_next;
        div_r_d = rem_next;
        cnt_d   = cnt_q + CNT_W'(1);
        if (div_last) begin
          crop_w_d = wide_q ? crop_fix : sw_q;
          crop_h_d = wide_q ? sh_q : crop_fix;
          div_n_d  = {(wide_q ? crop_fix : sw_q), STEP_FRAC'(0)};
          div_d_d  = dw_q;
          div_r_d  = '0;
          cnt_d    = '0;
          st_d     = ST_DIV_STEP;
        end
      end
      ST_DIV_STEP: begin
        div_n_d = quo_next;
        div_r_d = rem_next;
        cnt_d   = cnt_q + CNT_W'(1);
        if (div_last) begin
          step_d = quo_next;
          st_d   = ST_OFFS;
        end
      end
      ST_OFFS: begin
        off_x_d = COORD_W'((sw_q - crop_w_q) >> 1);
        off_y_d = COORD_W'((sh_q - crop_h_q) >> 1);
        st_d    = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
    if (wr) begin
      st_d = ST_PROD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      cnt_q    <= '0;
      crop_w_q <= CFG_W'(1);
      crop_h_q <= CFG_W'(1);
      step_q   <= STEP_W'(1 << STEP_FRAC);
      off_x_q  <= '0;
      off_y_q  <= '0;
    end else begin
      st_q     <= st_d;
      cnt_q    <= cnt_d;
      crop_w_q <= crop_w_d;
      crop_h_q <= crop_h_d;
      step_q   <= step_d;
      off_x_q  <= off_x_d;
      off_y_q  <= off_y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q    <= pa_d;
    pb_q    <= pb_d;
    wide_q  <= wide_d;
    div_n_q <= div_n_d;
    div_r_q <= div_r_d;
    div_d_q <= div_d_d;
  end

  assign busy_o = st_q != ST_IDLE;

  always_comb begin
    geom_o.ok     = size_ok(sw_q) && size_ok(sh_q) && size_ok(dw_q) && size_ok(dh_q);
    geom_o.sw     = sw_q;
    geom_o.sh     = sh_q;
    geom_o.dw     = dw_q;
    geom_o.dh     = dh_q;
    geom_o.crop_h = crop_h_q;
    geom_o.off_x  = off_x_q;
    geom_o.off_y  = off_y_q;
    geom_o.step   = step_q;
  end

  `CCNS_NEVER(a_cnt_range,
    ((st_q == ST_DIV_CROP) || (st_q == ST_DIV_STEP)) && (cnt_q >= CNT_W'(STEP_W)),
    "divider count out of range")
  `CCNS_ASSERT(a_step_nonzero,
    (st_q == ST_IDLE) && $past(st_q == ST_IDLE) && geom_o.ok |-> (step_q != '0),
    "zero x step with valid sizes")
  `CCNS_ASSERT(a_busy_after_write, wr |=> busy_o, "size write did not start the setup")

endmodule

// ===== hdl/cover_crop_nearest_scaler.sv =====
// Top level: pipelined cover-crop nearest-neighbor source address generator.
// Takes one destination pixel (dst_x, dst_y) per clock, unless a stalled output
// backs up to the input or setup is busy, and returns its source column, row
// and linear address; stages are the input register, the x-step and row
// multiplies, four stages of the row division (three quotient bits each), the
// row offset and clamp, and the address multiply into the output register. A
// stalled output holds only the stages behind it that are full. After each size
// register write the input is held off while a serial divider, one quotient
// bit per cycle, derives the crop size, the 16-bit fractional x step and the
// centering offsets; after reset the defaults are ready at once.
`include "assert_macros.svh"

module cover_crop_nearest_scaler
  import ccns_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [COORD_W-1:0] dst_x_i,
  input  logic [COORD_W-1:0] dst_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               valid_res_o,
  output logic [COORD_W-1:0] src_x_o,
  output logic [COORD_W-1:0] src_y_o,
  output logic [ADDR_W-1:0]  src_address_o
);

  localparam int S_DIV = 2;
  localparam int S_SY  = S_DIV + DIV_STAGES + 1;
  localparam int S_OUT = S_SY + 1;
  localparam int XP_W  = COORD_W + STEP_W;
  localparam int XS_W  = XP_W - STEP_FRAC;

  ccns_geom_t          geom;
  logic                busy;
  logic                take;
  logic [S_OUT:1]      v_q;
  logic [S_OUT:1]      en;
  logic                ok_q [1:S_OUT-1];

  logic [COORD_W-1:0]  x1_q, y1_q;
  logic [XP_W-1:0]     xprod;
  logic [PROD_W-1:0]   yprod;
  logic [XS_W-1:0]     xs2_q;
  ccns_div_t           div_q [S_DIV:S_SY-1];
  logic [XS_W:0]       sx_sum;
  logic [COORD_W-1:0]  sx_clamp;
  logic [COORD_W-1:0]  sx_q [S_DIV+1:S_SY];
  logic [COORD_W:0]    sy_sum;
  logic [COORD_W-1:0]  sy_clamp;
  logic [COORD_W-1:0]  sy7_q;
  logic [PROD_W-1:0]   addr;

  logic                res_q;
  logic [COORD_W-1:0]  src_x_q, src_y_q;
  logic [ADDR_W-1:0]   addr_q;

  ccns_setup u_setup (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .busy_o  (busy),
    .geom_o  (geom)
  );

  // a stage may load when empty or when the one after it moves
  always_comb begin
    en[S_OUT] = !v_q[S_OUT] || out_ready_i;
    for (int k = S_OUT - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[1] && !busy;
  assign take       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= take;
      end
      for (int k = 2; k <= S_OUT; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // stage 1: input register and range check
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      x1_q    <= dst_x_i;
      y1_q    <= dst_y_i;
      ok_q[1] <= geom.ok && ({1'b0, dst_x_i} < geom.dw) && ({1'b0, dst_y_i} < geom.dh);
    end
  end

  // stage 2: x step multiply, row numerator multiply
  assign xprod = XP_W'(x1_q) * XP_W'(geom.step);
  assign yprod = PROD_W'(y1_q) * PROD_W'(geom.crop_h);

  always_ff @(posedge clk_i) begin
    if (en[S_DIV]) begin
      xs2_q            <= xprod[XP_W-1:STEP_FRAC];
      ok_q[S_DIV]      <= ok_q[S_DIV-1];
      // quotient fits COORD_W bits, so the top half already sits below dh
      div_q[S_DIV].rem <= yprod[2*COORD_W-1:COORD_W];
      div_q[S_DIV].num <= yprod[COORD_W-1:0];
      div_q[S_DIV].quo <= '0;
    end
  end

  // column offset and clamp, alongside the first division stage
  assign sx_sum   = (XS_W+1)'(xs2_q) + (XS_W+1)'(geom.off_x);
  assign sx_clamp = (sx_sum >= (XS_W+1)'(geom.sw)) ? COORD_W'(geom.sw - 1'b1)
                                                    : sx_sum[COORD_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en[S_DIV+1]) begin
      sx_q[S_DIV+1] <= sx_clamp;
    end
  end

  for (genvar k = S_DIV + 1; k < S_SY; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        div_q[k] <= div_steps(div_q[k-1], geom.dh);
        ok_q[k]  <= ok_q[k-1];
      end
    end
  end

  for (genvar k = S_DIV + 2; k <= S_SY; k++) begin : g_sx
    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        sx_q[k] <= sx_q[k-1];
      end
    end
  end

  // row offset and clamp
  assign sy_sum   = (COORD_W+1)'(geom.off_y) + (COORD_W+1)'(div_q[S_SY-1].quo);
  assign sy_clamp = (sy_sum >= geom.sh) ? COORD_W'(geom.sh - 1'b1) : sy_sum[COORD_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en[S_SY]) begin
      sy7_q      <= sy_clamp;
      ok_q[S_SY] <= ok_q[S_SY-1];
    end
  end

  // linear address, invalid results read as zero
  assign addr = PROD_W'(sy7_q) * PROD_W'(geom.sw) + PROD_W'(sx_q[S_SY]);

  always_ff @(posedge clk_i) begin
    if (en[S_OUT]) begin
      res_q   <= ok_q[S_SY];
      src_x_q <= ok_q[S_SY] ? sx_q[S_SY] : '0;
      src_y_q <= ok_q[S_SY] ? sy7_q : '0;
      addr_q  <= ok_q[S_SY] ? addr[ADDR_W-1:0] : '0;
    end
  end

  assign out_valid_o   = v_q[S_OUT];
  assign valid_res_o   = res_q;
  assign src_x_o       = src_x_q;
  assign src_y_o       = src_y_q;
  assign src_address_o = addr_q;

  `CCNS_ASSERT(a_invalid_zero, out_valid_o && !valid_res_o |-> (src_x_o == '0) && (src_y_o == '0) && (src_address_o == '0), "invalid item with nonzero fields")
  `CCNS_ASSERT(a_src_bounds, out_valid_o && valid_res_o && !busy |-> ({1'b0, src_x_o} < geom.sw) && ({1'b0, src_y_o} < geom.sh), "source coordinate beyond source size")
  `CCNS_ASSERT(a_mid_hold, v_q[S_SY] && !en[S_SY+1] |=> v_q[S_SY] && $stable(sy7_q), "stalled row stage lost its item")

endmodule

// ===== test/tb.sv =====
// Testbench for the cover-crop nearest scaler: directed table, then random size settings.
`timescale 1ns / 1ps

module tb
  import ccns_pkg::*;
();

  localparam int CYCLE_LIMIT   = 400000;
  localparam int NUM_DIRECTED  = 25;
  localparam int RANDOM_PHASES = 14;
  localparam int ITEMS_PER_SET = 43;
  localparam int DRAIN_CYCLES  = 16;

  typedef struct packed {
    logic               ok;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [ADDR_W-1:0]  addr;
  } source_pixel_t;

  typedef struct packed {
    logic [CFG_W-1:0]   sw;
    logic [CFG_W-1:0]   sh;
    logic [CFG_W-1:0]   dw;
    logic [CFG_W-1:0]   dh;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               given;
    source_pixel_t      want;
  } directed_row_t;

  // Rows with given=1 carry a result read straight off the spec; the rest use the predictor.
  localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{1, 1, 1, 1, 0, 0, 1, '{1, 0, 0, 0}},
    '{1, 1, 1, 1, 1, 0, 1, '{0, 0, 0, 0}},
    '{1, 1, 1, 1, 0, 4095, 1, '{0, 0, 0, 0}},
    '{4096, 4096, 4096, 4096, 4095, 4095, 1, '{1, 4095, 4095, 24'hFFFFFF}},
    '{4096, 4096, 4096, 4096, 0, 0, 1, '{1, 0, 0, 0}},
    '{4096, 4096, 4096, 4096, 2730, 1365, 1, '{1, 2730, 1365, 5593770}},
    '{640, 480, 640, 480, 639, 479, 1, '{1, 639, 479, 307199}},
    '{640, 480, 640, 480, 640, 0, 1, '{0, 0, 0, 0}},
    '{0, 480, 640, 480, 0, 0, 1, '{0, 0, 0, 0}},
    '{640, 0, 640, 480, 0, 0, 1, '{0, 0, 0, 0}},
    '{640, 480, 0, 480, 0, 0, 1, '{0, 0, 0, 0}},
    '{640, 480, 640, 0, 0, 0, 1, '{0, 0, 0, 0}},
    '{4097, 480, 640, 480, 0, 0, 1, '{0, 0, 0, 0}},
    '{640, 480, 640, 8191, 0, 0, 1, '{0, 0, 0, 0}},
    '{1920, 1080, 1080, 1080, 0, 0, 0, '{0, 0, 0, 0}},
    '{1920, 1080, 1080, 1080, 1079, 1079, 0, '{0, 0, 0, 0}},
    '{1920, 1080, 1080, 1080, 540, 540, 0, '{0, 0, 0, 0}},
    '{1080, 1920, 1920, 1080, 1919, 1079, 0, '{0, 0, 0, 0}},
    '{1080, 1920, 1920, 1080, 960, 3, 0, '{0, 0, 0, 0}},
    '{1, 4096, 4096, 1, 4095, 0, 0, '{0, 0, 0, 0}},
    '{4096, 1, 1, 4096, 0, 4095, 0, '{0, 0, 0, 0}},
    '{4096, 4096, 1, 1, 0, 0, 0, '{0, 0, 0, 0}},
    '{2, 2, 4096, 4096, 4095, 4095, 0, '{0, 0, 0, 0}},
    '{3, 5, 7, 11, 6, 10, 0, '{0, 0, 0, 0}},
    '{3, 5, 7, 11, 7, 0, 0, '{0, 0, 0, 0}}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [APB_AW-1:0]  paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [COORD_W-1:0] dst_x_i;
  logic [COORD_W-1:0] dst_y_i;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               valid_res_o;
  logic [COORD_W-1:0] src_x_o;
  logic [COORD_W-1:0] src_y_o;
  logic [ADDR_W-1:0]  src_address_o;

  logic [CFG_W-1:0] size_src_w, size_src_h, size_dst_w, size_dst_h;
  source_pixel_t    expected_pixels [$];
  bit               steady;
  int               fail_count    = 0;
  int               cycle_count   = 0;
  int               pixels_sent   = 0;
  int               mapped_seen   = 0;
  int               setting_count = 0;

  cover_crop_nearest_scaler dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .dst_x_i, .dst_y_i,
    .out_valid_o, .out_ready_i, .valid_res_o, .src_x_o, .src_y_o, .src_address_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic bit dim_in_range(longint unsigned v);
    return v != 0 && v <= MAX_DIM;
  endfunction

  // Crop window keeps the destination aspect and is centered; x uses a 13.16 step.
  function automatic source_pixel_t map_to_source(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    source_pixel_t   r;
    longint unsigned sw, sh, dw, dh, cw, ch, ox, oy, step, sx, sy, a;
    r  = '0;
    sw = size_src_w;
    sh = size_src_h;
    dw = size_dst_w;
    dh = size_dst_h;
    if (!dim_in_range(sw) || !dim_in_range(sh) || !dim_in_range(dw) || !dim_in_range(dh))
      return r;
    if (x >= dw || y >= dh)
      return r;
    cw = sw;
    ch = sh;
    if (sw * dh > dw * sh) cw = dw * sh / dh;
    else ch = dh * sw / dw;
    if (cw == 0) cw = 1;
    if (ch == 0) ch = 1;
    ox   = (cw <= sw) ? (sw - cw) / 2 : 0;
    oy   = (ch <= sh) ? (sh - ch) / 2 : 0;
    step = (cw << STEP_FRAC) / dw;
    sx   = ox + ((x * step) >> STEP_FRAC);
    if (sx >= sw) sx = sw - 1;
    sy   = oy + (y * ch) / dh;
    if (sy >= sh) sy = sh - 1;
    a      = sy * sw + sx;
    r.ok   = 1'b1;
    r.col  = sx[COORD_W-1:0];
    r.row  = sy[COORD_W-1:0];
    r.addr = a[ADDR_W-1:0];
    return r;
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim();
    int r;
    r = $urandom_range(99);
    if (r < 4) return '0;
    if (r < 8) return CFG_W'($urandom_range(8191, 4097));
    if (r < 16) return CFG_W'(1);
    if (r < 24) return CFG_W'(4096);
    if (r < 50) return CFG_W'($urandom_range(16, 1));
    return CFG_W'($urandom_range(4096, 1));
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord(logic [CFG_W-1:0] lim);
    if (lim != 0 && $urandom_range(99) < 85)
      return COORD_W'($urandom_range((lim > MAX_DIM) ? MAX_DIM - 1 : lim - 1, 0));
    return COORD_W'($urandom_range(4095, 0));
  endfunction

  task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [APB_DW-1:0] data,
                            output logic [APB_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_size(input logic [1:0] idx, input logic [CFG_W-1:0] v,
                          input logic [APB_DW-CFG_W-1:0] junk);
    logic [APB_DW-1:0] rd;
    apb_access(1'b1, idx, {junk, v}, rd);
    case (idx)
      REG_SRC_WIDTH:  size_src_w = v;
      REG_SRC_HEIGHT: size_src_h = v;
      REG_DST_WIDTH:  size_dst_w = v;
      REG_DST_HEIGHT: size_dst_h = v;
      default: ;
    endcase
    apb_access(1'b0, idx, '0, rd);
    if (rd !== APB_DW'(v)) begin
      $error("register %0d readback: expected %0d, got %0d", idx, v, rd);
      fail_count++;
    end
  endtask

  // Only registers that change are written unless every_reg is set.
  task automatic apply_sizes(input logic [CFG_W-1:0] sw, sh, dw, dh, input bit every_reg,
                             input bit junk_bits);
    logic [APB_DW-CFG_W-1:0] j;
    j = junk_bits ? (APB_DW-CFG_W)'($urandom() >> CFG_W) : '0;
    if (every_reg || sw != size_src_w) set_size(REG_SRC_WIDTH, sw, j);
    if (every_reg || sh != size_src_h) set_size(REG_SRC_HEIGHT, sh, j);
    if (every_reg || dw != size_dst_w) set_size(REG_DST_WIDTH, dw, j);
    if (every_reg || dh != size_dst_h) set_size(REG_DST_HEIGHT, dh, j);
    setting_count++;
  endtask

  task automatic wait_for_results();
    while (expected_pixels.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_pixel(input logic [COORD_W-1:0] x, y, input bit use_given,
                            input source_pixel_t given);
    while (!steady && $urandom_range(99) < 22) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    dst_x_i    <= x;
    dst_y_i    <= y;
    do @(posedge clk_i); while (!in_ready_o);
    expected_pixels.push_back(use_given ? given : map_to_source(x, y));
    pixels_sent++;
  endtask

  always @(posedge clk_i) out_ready_i <= steady || ($urandom_range(99) >= 22);

  always @(posedge clk_i) begin : check_results
    source_pixel_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pixels.size() == 0) begin
        $error("result with no pending item: src_x %0d src_y %0d", src_x_o, src_y_o);
        fail_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (valid_res_o) mapped_seen++;
        if (valid_res_o !== want.ok) begin
          $error("valid_res: expected %0d, got %0d", want.ok, valid_res_o);
          fail_count++;
        end
        if (src_x_o !== want.col) begin
          $error("src_x: expected %0d, got %0d", want.col, src_x_o);
          fail_count++;
        end
        if (src_y_o !== want.row) begin
          $error("src_y: expected %0d, got %0d", want.row, src_y_o);
          fail_count++;
        end
        if (src_address_o !== want.addr) begin
          $error("src_address: expected %0d, got %0d", want.addr, src_address_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items pending", cycle_count,
               expected_pixels.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    directed_row_t     r;
    logic [CFG_W-1:0]  sw, sh, dw, dh;
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    dst_x_i     = '0;
    dst_y_i     = '0;
    steady      = 1'b0;
    size_src_w  = CFG_W'(1);
    size_src_h  = CFG_W'(1);
    size_dst_w  = CFG_W'(1);
    size_dst_h  = CFG_W'(1);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      r = DIRECTED_ROWS[i];
      if (r.sw != size_src_w || r.sh != size_src_h || r.dw != size_dst_w ||
          r.dh != size_dst_h) begin
        in_valid_i <= 1'b0;
        wait_for_results();
        apply_sizes(r.sw, r.sh, r.dw, r.dh, 1'b0, 1'b0);
      end
      send_pixel(r.x, r.y, r.given, r.want);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      in_valid_i <= 1'b0;
      wait_for_results();
      steady = (p == 6);
      sw = pick_dim();
      sh = pick_dim();
      dw = pick_dim();
      dh = pick_dim();
      apply_sizes(sw, sh, dw, dh, 1'b1, 1'b1);
      for (int k = 0; k < ITEMS_PER_SET; k++) begin
        // hold the sender until the pipe is empty, then resume mid-setting
        if (p == 3 && k == ITEMS_PER_SET / 2) begin
          in_valid_i <= 1'b0;
          wait_for_results();
        end
        send_pixel(pick_coord(size_dst_w), pick_coord(size_dst_h), 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    steady = 1'b0;
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("checked %0d pixel mappings over %0d size settings, %0d inside the crop window",
             pixels_sent, setting_count, mapped_seen);
    $display("random stalls on both sides, one stall-free setting, one full drain mid-stream");
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
